// ===== design/mspt_pkg.sv =====
package mspt_pkg;

    localparam int NUM_SOURCES = 4;
    localparam int IDX_W = (NUM_SOURCES > 1) ? $clog2(NUM_SOURCES) : 1;
    localparam int TIME_W = 64;
    localparam int IVL_W = 48;
    localparam int BIT_CNT_W = $clog2(TIME_W);
    localparam int CFG_IDX_W = 3;

    localparam logic [CFG_IDX_W-1:0] REG_SOURCE_COUNT = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_INTERVAL_A = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_INTERVAL_B = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_INTERVAL_C = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_INTERVAL_D = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_TYPE_CODES = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_WINDOW_HALF = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_STAGGER_STEP = 3'd7;

    localparam logic [2:0] SOURCE_COUNT_RST = 3'd1;
    localparam logic [IVL_W-1:0] INTERVAL_RST = 48'd62500000;
    localparam logic [15:0] WINDOW_HALF_RST = 16'd1000;
    localparam logic [15:0] STAGGER_STEP_RST = 16'd5000;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DIV_LOAD,
        ST_DIV_RUN,
        ST_DUE_WR,
        ST_SCAN_INIT,
        ST_SCAN,
        ST_CHECK,
        ST_EMIT
    } state_t;

    typedef struct packed {
        logic load_item;
        logic set_started;
        logic div_load;
        logic div_step;
        logic due_write;
        logic scan_init;
        logic scan_step;
        logic advance;
        logic load_out;
    } cmd_t;

    typedef struct packed {
        logic in_tick;
        logic started;
        logic idx_last;
        logic single_source;
        logic div_last;
        logic fire;
        logic out_free;
    } status_t;

endpackage

// ===== design/mspt_ctrl.sv =====
module mspt_ctrl
    import mspt_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    in_valid,
    output logic    in_ready,
    input  status_t status,
    output cmd_t    cmd
);

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd = '0;
        in_ready = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.load_item = 1'b1;
                    if (!status.in_tick)
                    begin
                        cmd.set_started = 1'b1;
                        state_next = ST_DIV_LOAD;
                    end
                    else if (status.started)
                    begin
                        state_next = ST_SCAN_INIT;
                    end
                end
            end
            ST_DIV_LOAD:
            begin
                cmd.div_load = 1'b1;
                state_next = ST_DIV_RUN;
            end
            ST_DIV_RUN:
            begin
                cmd.div_step = 1'b1;
                if (status.div_last)
                begin
                    state_next = ST_DUE_WR;
                end
            end
            ST_DUE_WR:
            begin
                cmd.due_write = 1'b1;
                state_next = status.idx_last ? ST_IDLE : ST_DIV_LOAD;
            end
            ST_SCAN_INIT:
            begin
                cmd.scan_init = 1'b1;
                state_next = status.single_source ? ST_CHECK : ST_SCAN;
            end
            ST_SCAN:
            begin
                cmd.scan_step = 1'b1;
                if (status.idx_last)
                begin
                    state_next = ST_CHECK;
                end
            end
            ST_CHECK:
            begin
                state_next = status.fire ? ST_EMIT : ST_IDLE;
            end
            ST_EMIT:
            begin
                if (status.out_free)
                begin
                    cmd.load_out = 1'b1;
                    cmd.advance = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

// ===== design/mspt_datapath.sv =====
module mspt_datapath
    import mspt_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_valid,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [31:0]          cfg_data_lo,
    input  logic [IVL_W-1:0]     cfg_data_ivl,
    input  logic                 operation,
    input  logic [TIME_W-1:0]    now_time,
    output logic                 out_valid,
    input  logic                 out_ready,
    output logic [TIME_W-1:0]    cand_time,
    output logic [TIME_W-1:0]    window_start,
    output logic [TIME_W-1:0]    window_end,
    output logic [7:0]           cand_type,
    output logic [1:0]           source_index,
    input  cmd_t                 cmd,
    output status_t              status
);

    logic [2:0]           source_count_reg;
    logic [IVL_W-1:0]     interval_reg [4];
    logic [31:0]          type_codes_reg;
    logic [15:0]          window_half_reg;
    logic [15:0]          stagger_step_reg;

    logic [TIME_W-1:0]    due_reg [NUM_SOURCES];
    logic                 started_reg;
    logic [TIME_W-1:0]    now_reg;
    logic [TIME_W-1:0]    base_reg;
    logic [IDX_W-1:0]     idx_reg;
    logic [TIME_W-1:0]    div_reg;
    logic [IVL_W-1:0]     rem_reg;
    logic [BIT_CNT_W-1:0] bit_cnt_reg;
    logic [IDX_W-1:0]     best_idx_reg;
    logic [TIME_W-1:0]    best_time_reg;
    logic                 out_valid_reg;

    logic [IDX_W-1:0]     n_last;
    logic [IDX_W-1:0]     ivl_sel;
    logic [IVL_W-1:0]     ivl_raw;
    logic [IVL_W-1:0]     ivl;
    logic [IVL_W:0]       rem_shift;
    logic [IVL_W-1:0]     rem_next;
    logic [TIME_W-1:0]    scan_time;
    logic [IDX_W-1:0]     idx_inc;

    // active count 1..NUM_SOURCES, kept as last index
    always_comb
    begin
        if (source_count_reg == 3'd0)
        begin
            n_last = '0;
        end
        else if (32'(source_count_reg) > NUM_SOURCES)
        begin
            n_last = IDX_W'(NUM_SOURCES - 1);
        end
        else
        begin
            n_last = IDX_W'(source_count_reg - 3'd1);
        end
    end

    assign idx_inc = idx_reg + IDX_W'(1);
    assign ivl_sel = cmd.advance ? best_idx_reg : idx_reg;
    assign ivl_raw = interval_reg[2'(ivl_sel)];
    assign ivl = (ivl_raw == '0) ? IVL_W'(1) : ivl_raw;

    // restoring remainder step, one dividend bit per cycle
    assign rem_shift = {rem_reg, div_reg[TIME_W-1]};
    assign rem_next = (rem_shift >= {1'b0, ivl}) ? IVL_W'(rem_shift - {1'b0, ivl})
                                                  : IVL_W'(rem_shift);

    assign scan_time = due_reg[idx_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            source_count_reg <= SOURCE_COUNT_RST;
            for (int i = 0; i < 4; i++)
            begin
                interval_reg[i] <= INTERVAL_RST;
            end
            type_codes_reg <= '0;
            window_half_reg <= WINDOW_HALF_RST;
            stagger_step_reg <= STAGGER_STEP_RST;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                REG_SOURCE_COUNT: source_count_reg <= cfg_data_lo[2:0];
                REG_INTERVAL_A:   interval_reg[0] <= cfg_data_ivl;
                REG_INTERVAL_B:   interval_reg[1] <= cfg_data_ivl;
                REG_INTERVAL_C:   interval_reg[2] <= cfg_data_ivl;
                REG_INTERVAL_D:   interval_reg[3] <= cfg_data_ivl;
                REG_TYPE_CODES:   type_codes_reg <= cfg_data_lo;
                REG_WINDOW_HALF:  window_half_reg <= cfg_data_lo[15:0];
                REG_STAGGER_STEP: stagger_step_reg <= cfg_data_lo[15:0];
                default:          ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NUM_SOURCES; i++)
            begin
                due_reg[i] <= '0;
            end
            started_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.set_started)
            begin
                started_reg <= 1'b1;
            end
            if (cmd.due_write)
            begin
                due_reg[idx_reg] <= base_reg - TIME_W'(rem_reg) + TIME_W'(ivl);
            end
            else if (cmd.advance)
            begin
                due_reg[best_idx_reg] <= best_time_reg + TIME_W'(ivl);
            end
            if (cmd.load_out)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_item)
        begin
            now_reg <= now_time;
            base_reg <= now_time;
            idx_reg <= '0;
        end
        if (cmd.div_load)
        begin
            div_reg <= base_reg;
            rem_reg <= '0;
            bit_cnt_reg <= '0;
        end
        if (cmd.div_step)
        begin
            div_reg <= {div_reg[TIME_W-2:0], 1'b0};
            rem_reg <= rem_next;
            bit_cnt_reg <= bit_cnt_reg + BIT_CNT_W'(1);
        end
        if (cmd.due_write)
        begin
            base_reg <= base_reg + TIME_W'(stagger_step_reg);
            idx_reg <= idx_inc;
        end
        if (cmd.scan_init)
        begin
            best_idx_reg <= '0;
            best_time_reg <= due_reg[0];
            idx_reg <= IDX_W'(1);
        end
        if (cmd.scan_step)
        begin
            if (scan_time < best_time_reg)
            begin
                best_idx_reg <= idx_reg;
                best_time_reg <= scan_time;
            end
            idx_reg <= idx_inc;
        end
        if (cmd.load_out)
        begin
            cand_time <= best_time_reg;
            window_start <= best_time_reg - TIME_W'(window_half_reg);
            window_end <= best_time_reg + TIME_W'(window_half_reg);
            cand_type <= type_codes_reg[8 * 32'(2'(best_idx_reg)) +: 8];
            source_index <= 2'(best_idx_reg);
        end
    end

    assign out_valid = out_valid_reg;

    always_comb
    begin
        status.in_tick = operation;
        status.started = started_reg;
        status.idx_last = (idx_reg == n_last);
        status.single_source = (n_last == '0);
        status.div_last = (bit_cnt_reg == BIT_CNT_W'(TIME_W - 1));
        status.fire = (best_time_reg <= now_reg);
        status.out_free = !out_valid_reg || out_ready;
    end

    a_started_sticks: assert property (@(posedge clk) disable iff (!rst_n)
        started_reg |=> started_reg)
        else $error("started flag dropped");

    a_load_when_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load_out |-> (!out_valid_reg || out_ready))
        else $error("output register overwritten");

    a_rem_below_ivl: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.div_step |=> (rem_reg < ivl))
        else $error("remainder not below interval");

    a_fire_only_due: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.advance |-> (best_time_reg <= now_reg))
        else $error("source advanced before due");

endmodule

// ===== design/multi_source_periodic_trigger.sv =====
// Periodic trigger candidate generator for up to NUM_SOURCES sources. A start
// request computes each source's first due time with a shared 1-bit-per-cycle
// remainder unit: per active source a load, 64 divide steps and a write.
// A tick request scans the due times one source per cycle, then checks the
// earliest; a due one waits for a free output register and is emitted. A tick
// before the first start does nothing. The candidate sits in an output
// register, so the next request is taken while it waits. The user must write
// config only while idle; the block does not enforce it. cfg_ready is always high.
module multi_source_periodic_trigger
    import mspt_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [IVL_W-1:0]     cfg_data,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  logic                 operation,
    input  logic [TIME_W-1:0]    now_time,
    output logic                 out_valid,
    input  logic                 out_ready,
    output logic [TIME_W-1:0]    cand_time,
    output logic [TIME_W-1:0]    window_start,
    output logic [TIME_W-1:0]    window_end,
    output logic [7:0]           cand_type,
    output logic [1:0]           source_index
);

    cmd_t    cmd;
    status_t status;

    assign cfg_ready = 1'b1;

    mspt_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .status   (status),
        .cmd      (cmd)
    );

    mspt_datapath u_datapath (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_valid    (cfg_valid),
        .cfg_index    (cfg_index),
        .cfg_data_lo  (cfg_data[31:0]),
        .cfg_data_ivl (cfg_data),
        .operation    (operation),
        .now_time     (now_time),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .cand_time    (cand_time),
        .window_start (window_start),
        .window_end   (window_end),
        .cand_type    (cand_type),
        .source_index (source_index),
        .cmd          (cmd),
        .status       (status)
    );

endmodule

// ===== sim/tb_top.sv =====
`timescale 1ns / 100ps

module tb_top;
    import mspt_pkg::*;

    localparam logic OP_START = 1'b0;
    localparam logic OP_TICK = 1'b1;
    localparam int DRAIN_CYCLES = 300;
    localparam int RANDOM_ITEMS = 850;

    typedef struct {
        logic             op;
        logic [TIME_W-1:0] now;
    } req_t;

    typedef struct {
        logic [TIME_W-1:0] t;
        logic [TIME_W-1:0] ws;
        logic [TIME_W-1:0] we;
        logic [7:0]        typ;
        logic [1:0]        idx;
    } cand_t;

    logic                 clk = 1'b0;
    logic                 rst_n = 1'b0;
    logic                 cfg_valid = 1'b0;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [IVL_W-1:0]     cfg_data = '0;
    logic                 in_valid = 1'b0;
    logic                 in_ready;
    logic                 operation = 1'b0;
    logic [TIME_W-1:0]    now_time = '0;
    logic                 out_valid;
    logic                 out_ready = 1'b0;
    logic [TIME_W-1:0]    cand_time;
    logic [TIME_W-1:0]    window_start;
    logic [TIME_W-1:0]    window_end;
    logic [7:0]           cand_type;
    logic [1:0]           source_index;

    multi_source_periodic_trigger uut (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .operation    (operation),
        .now_time     (now_time),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .cand_time    (cand_time),
        .window_start (window_start),
        .window_end   (window_end),
        .cand_type    (cand_type),
        .source_index (source_index)
    );

    req_t  req_q[$];
    cand_t exp_cands[$];
    int    errors = 0;
    int    send_idle = 0;
    int    recv_idle = 0;
    logic  req_accepted = 1'b0;

    // predictor copy of registers and schedule
    logic [2:0]        m_count;
    logic [IVL_W-1:0]  m_ivl[4];
    logic [31:0]       m_types;
    logic [15:0]       m_win;
    logic [15:0]       m_stag;
    logic [TIME_W-1:0] m_due[NUM_SOURCES];
    logic              m_started;

    // stimulus-side view of the settings
    logic [2:0]        g_count;
    logic [IVL_W-1:0]  g_ivl[4];
    logic [15:0]       g_stag;
    logic [TIME_W-1:0] g_span;
    logic [TIME_W-1:0] g_cursor = '0;

    initial
    begin
        forever #1 clk = ~clk;
    end

    initial
    begin
        #2_000_000;
        $display("multi_source_periodic_trigger test failed");
        $finish;
    end

    function automatic int active_sources(input logic [2:0] c);
        if (c == 3'd0)
            return 1;
        if (c > NUM_SOURCES)
            return NUM_SOURCES;
        return int'(c);
    endfunction

    function automatic logic [TIME_W-1:0] ivl_used(input logic [IVL_W-1:0] v);
        return (v == '0) ? 64'd1 : {16'd0, v};
    endfunction

    function automatic logic [TIME_W-1:0] rnd64();
        return {$urandom, $urandom};
    endfunction

    task automatic trigger_step(input logic op, input logic [TIME_W-1:0] now);
        int                n;
        int                i;
        int                best;
        logic [TIME_W-1:0] base;
        logic [TIME_W-1:0] iv;
        cand_t             c;
        n = active_sources(m_count);
        if (op == OP_START)
        begin
            for (i = 0; i < n; i++)
            begin
                base = now + m_stag * i;
                iv = ivl_used(m_ivl[i % 4]);
                m_due[i] = (base / iv + 64'd1) * iv;
            end
            m_started = 1'b1;
        end
        else if (m_started)
        begin
            best = 0;
            for (i = 1; i < n; i++)
                if (m_due[i] < m_due[best])
                    best = i;
            if (m_due[best] <= now)
            begin
                c.t = m_due[best];
                c.ws = m_due[best] - m_win;
                c.we = m_due[best] + m_win;
                c.typ = m_types[8 * (best % 4) +: 8];
                c.idx = best[1:0];
                exp_cands.insert(exp_cands.size(), c);
                m_due[best] = m_due[best] + ivl_used(m_ivl[best % 4]);
            end
        end
    endtask

    task automatic check_field(input string name, input logic [TIME_W-1:0] want,
                               input logic [TIME_W-1:0] got);
        if (want !== got)
        begin
            $display("%0t: %s mismatch, expected %h, got %h", $time, name, want, got);
            errors++;
        end
    endtask

    always @(posedge clk)
    begin
        cand_t c;
        int    i;
        if (!rst_n)
        begin
            req_accepted <= 1'b0;
            m_count = SOURCE_COUNT_RST;
            for (i = 0; i < 4; i++)
                m_ivl[i] = INTERVAL_RST;
            m_types = '0;
            m_win = WINDOW_HALF_RST;
            m_stag = STAGGER_STEP_RST;
            for (i = 0; i < NUM_SOURCES; i++)
                m_due[i] = '0;
            m_started = 1'b0;
        end
        else
        begin
            req_accepted <= in_valid && in_ready;
            if (out_valid && out_ready)
            begin
                if (exp_cands.size() == 0)
                begin
                    $display("%0t: unexpected candidate, time %h", $time, cand_time);
                    errors++;
                end
                else
                begin
                    c = exp_cands.pop_front();
                    check_field("cand_time", c.t, cand_time);
                    check_field("window_start", c.ws, window_start);
                    check_field("window_end", c.we, window_end);
                    check_field("cand_type", {56'd0, c.typ}, {56'd0, cand_type});
                    check_field("source_index", {62'd0, c.idx}, {62'd0, source_index});
                end
            end
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    REG_SOURCE_COUNT: m_count = cfg_data[2:0];
                    REG_INTERVAL_A: m_ivl[0] = cfg_data;
                    REG_INTERVAL_B: m_ivl[1] = cfg_data;
                    REG_INTERVAL_C: m_ivl[2] = cfg_data;
                    REG_INTERVAL_D: m_ivl[3] = cfg_data;
                    REG_TYPE_CODES: m_types = cfg_data[31:0];
                    REG_WINDOW_HALF: m_win = cfg_data[15:0];
                    REG_STAGGER_STEP: m_stag = cfg_data[15:0];
                    default: ;
                endcase
            end
            if (in_valid && in_ready)
                trigger_step(operation, now_time);
        end
    end

    // request driver
    always @(negedge clk)
    begin
        req_t r;
        if (rst_n && (!in_valid || req_accepted))
        begin
            if (req_q.size() != 0 && $urandom_range(99) >= send_idle)
            begin
                r = req_q.pop_front();
                in_valid <= 1'b1;
                operation <= r.op;
                now_time <= r.now;
            end
            else
                in_valid <= 1'b0;
        end
    end

    always @(negedge clk)
        out_ready <= ($urandom_range(99) >= recv_idle);

    task automatic push_req(input logic op, input logic [TIME_W-1:0] now);
        req_t r;
        r.op = op;
        r.now = now;
        req_q.insert(req_q.size(), r);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [IVL_W-1:0] data);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        do @(posedge clk); while (!cfg_ready);
    endtask

    task automatic set_regs(input logic [2:0] cnt, input logic [IVL_W-1:0] a,
                            input logic [IVL_W-1:0] b, input logic [IVL_W-1:0] c,
                            input logic [IVL_W-1:0] d, input logic [31:0] typ,
                            input logic [15:0] win, input logic [15:0] stag);
        int i;
        write_reg(REG_SOURCE_COUNT, {45'd0, cnt});
        write_reg(REG_INTERVAL_A, a);
        write_reg(REG_INTERVAL_B, b);
        write_reg(REG_INTERVAL_C, c);
        write_reg(REG_INTERVAL_D, d);
        write_reg(REG_TYPE_CODES, {16'd0, typ});
        write_reg(REG_WINDOW_HALF, {32'd0, win});
        write_reg(REG_STAGGER_STEP, {32'd0, stag});
        @(negedge clk);
        cfg_valid <= 1'b0;
        g_count = cnt;
        g_ivl[0] = a;
        g_ivl[1] = b;
        g_ivl[2] = c;
        g_ivl[3] = d;
        g_stag = stag;
        g_span = '1;
        for (i = 0; i < active_sources(g_count); i++)
            if (ivl_used(g_ivl[i % 4]) < g_span)
                g_span = ivl_used(g_ivl[i % 4]);
    endtask

    // wait until every request is taken and every candidate seen, then let a
    // start request that yields nothing finish its divide pass
    task automatic wait_drained();
        while (req_q.size() != 0 || in_valid || exp_cands.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    function automatic logic [IVL_W-1:0] pick_interval();
        int r;
        r = $urandom_range(99);
        if (r < 5)
            return '0;
        if (r < 55)
            return IVL_W'($urandom_range(1, 64));
        if (r < 75)
            return IVL_W'($urandom_range(65, 5000));
        if (r < 90)
            return IVL_W'($urandom_range(5001, 3000000));
        if (r < 97)
            return IVL_W'(rnd64());
        return '1;
    endfunction

    function automatic logic [TIME_W-1:0] pick_start();
        int r;
        r = $urandom_range(99);
        if (r < 50)
            return rnd64();
        if (r < 75)
            return TIME_W'($urandom_range(0, 5000));
        return 64'hFFFF_FFFF_FFFF_FFFF - $urandom_range(0, 200000);
    endfunction

    task automatic gen_phase(input int n);
        int                k;
        int                r;
        logic [TIME_W-1:0] step;
        if ($urandom_range(99) < 85)
        begin
            g_cursor = pick_start();
            push_req(OP_START, g_cursor);
        end
        for (k = 0; k < n; k++)
        begin
            r = $urandom_range(99);
            if (r < 8)
                push_req(1'($urandom_range(1)), rnd64());
            else if (r < 12)
            begin
                g_cursor = pick_start();
                push_req(OP_START, g_cursor);
            end
            else
            begin
                if (r < 22)
                    step = rnd64() % (2 * g_span + 4 * g_stag + 1);
                else
                    step = rnd64() % (2 * g_span + 1);
                g_cursor = g_cursor + step;
                push_req(OP_TICK, g_cursor);
            end
        end
    endtask

    initial
    begin
        int          done;
        int          n;
        int          r;
        logic [15:0] win;
        logic [15:0] stag;

        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        send_idle = 36;
        recv_idle = 78;

        // ticks before start, then the reset settings
        push_req(OP_TICK, 64'd0);
        push_req(OP_TICK, '1);
        push_req(OP_START, 64'd0);
        push_req(OP_TICK, 64'd62_499_999);
        push_req(OP_TICK, 64'd62_500_000);
        push_req(OP_TICK, '1);
        push_req(OP_TICK, '1);
        wait_drained();

        // zero and extreme intervals, wrap on start and window bounds, restart
        set_regs(3'd4, 48'd0, 48'd1, '1, 48'd7, 32'hA55A_FF00, 16'hFFFF, 16'hFFFF);
        push_req(OP_START, '1);
        push_req(OP_TICK, 64'd0);
        push_req(OP_TICK, 64'd0);
        push_req(OP_TICK, 64'd70000);
        push_req(OP_TICK, 64'd70000);
        push_req(OP_TICK, '1);
        push_req(OP_TICK, '1);
        push_req(OP_TICK, '1);
        push_req(OP_START, 64'd5);
        push_req(OP_TICK, 64'd5);
        push_req(OP_TICK, 64'd6);
        wait_drained();

        // count above range, equal due times: ties go to the lower index
        set_regs(3'd7, 48'd10, 48'd10, 48'd10, 48'd10, 32'h5AA5_00FF, 16'd0, 16'd0);
        push_req(OP_START, 64'd3);
        push_req(OP_TICK, 64'd10);
        push_req(OP_TICK, 64'd10);
        push_req(OP_TICK, 64'd10);
        push_req(OP_TICK, 64'd10);
        push_req(OP_TICK, 64'd20);
        wait_drained();

        done = 0;
        while (done < RANDOM_ITEMS)
        begin
            n = $urandom_range(15, 60);
            if (done < RANDOM_ITEMS / 3)
            begin
                send_idle = 36;
                recv_idle = 78;
            end
            else if (done < 2 * RANDOM_ITEMS / 3)
            begin
                send_idle = 78;
                recv_idle = 36;
            end
            else
            begin
                send_idle = 0;
                recv_idle = 0;
            end
            r = $urandom_range(99);
            win = (r < 10) ? 16'd0 : (r < 20) ? 16'hFFFF : 16'($urandom);
            r = $urandom_range(99);
            stag = (r < 20) ? 16'd0 : (r < 70) ? 16'($urandom_range(1, 100)) :
                   (r < 90) ? 16'($urandom) : 16'hFFFF;
            set_regs(3'($urandom_range(0, 7)), pick_interval(), pick_interval(),
                     pick_interval(), pick_interval(), $urandom, win, stag);
            gen_phase(n);
            wait_drained();
            done += n;
        end

        if (errors == 0)
            $display("multi_source_periodic_trigger test passed");
        else
            $display("multi_source_periodic_trigger test failed");
        $finish;
    end

endmodule
